@@ rtl/core/sact_pkg.sv @@
// sact_pkg: shared types, constants and helper functions of the cache tag controller
// used by the channel interfaces, the tag memory, the compare unit and the top level
package sact_pkg;

	localparam int NUM_WAYS = 4;
	localparam int MAX_SETS = 64;
	localparam int ENTRIES  = MAX_SETS * NUM_WAYS;

	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 32;
	localparam int LFSR_W  = 16;
	localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int SIB_W  = 3;
	localparam int LOB_W  = 4;
	localparam int POL_W  = 2;
	localparam int CFG_W  = 4;
	localparam int CIDX_W = 2;

	localparam logic [SIB_W-1:0]  SIB_RESET  = 3'd6;
	localparam logic [LOB_W-1:0]  LOB_RESET  = 4'd4;
	localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

	// register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_SET_INDEX_BITS     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LINE_OFFSET_BITS   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_REPLACEMENT_POLICY = 2'd2;

	// replacement policy codes, bit 1 means random
	localparam logic [POL_W-1:0] POL_LRU        = 2'd0;
	localparam logic [POL_W-1:0] POL_FIFO       = 2'd1;
	localparam logic [POL_W-1:0] POL_RANDOM     = 2'd2;
	localparam logic [POL_W-1:0] POL_RANDOM_ALT = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              is_store;
	} req_t;

	typedef struct packed {
		logic hit;
		logic needs_writeback;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic match;
		logic less;
	} cmp_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	function automatic logic [ENTRY_W-1:0] entry_addr(input logic [SET_W-1:0] set_idx,
			input logic [WAY_W-1:0] way);
		return ENTRY_W'(set_idx) * ENTRY_W'(NUM_WAYS) + ENTRY_W'(way);
	endfunction

endpackage

@@ rtl/core/sact_req_if.sv @@
// sact_req_if: access request channel, valid/ready with address and write flag
// depends on sact_pkg for the payload type
interface sact_req_if;
	logic              valid;
	logic              ready;
	sact_pkg::req_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sact_rsp_if.sv @@
// sact_rsp_if: access result channel, valid/ready with hit and writeback flags
// depends on sact_pkg for the payload type
interface sact_rsp_if;
	logic              valid;
	logic              ready;
	sact_pkg::rsp_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sact_tag_ram.sv @@
// sact_tag_ram: tag and stamp store, one write port and one registered read port
// depends on sact_pkg for the entry type and depth
module sact_tag_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [sact_pkg::ENTRY_W-1:0]  waddr,
	input  sact_pkg::entry_t              wdata,
	input  logic [sact_pkg::ENTRY_W-1:0]  raddr,
	output sact_pkg::entry_t              rdata
);

	sact_pkg::entry_t mem [sact_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/sact_cmp_unit.sv @@
// sact_cmp_unit: shared compare unit, tag match and stamp ordering for one way a cycle
// depends on sact_pkg for the entry and result types
module sact_cmp_unit (
	input  sact_pkg::entry_t                entry,
	input  logic                            entry_valid,
	input  logic [sact_pkg::ADDR_W-1:0]     line,
	input  logic [sact_pkg::STAMP_W-1:0]    min_stamp,
	output sact_pkg::cmp_t                  res
);

	always_comb begin
		res.match = entry_valid && (entry.tag == line);
		res.less  = entry.stamp < min_stamp;
	end

endmodule

@@ rtl/core/set_assoc_cache_tag_controller.sv @@
// set_assoc_cache_tag_controller: set-associative write-back cache tag controller
// depends on sact_pkg, sact_req_if, sact_rsp_if, sact_tag_ram and sact_cmp_unit
//
// usage
// - req carries one access (byte address, write flag) per transfer; rsp returns one
//   result (hit, needs_writeback) per access, in order
// - configuration: cfg_we writes cfg_data into register cfg_idx (0 set index bits,
//   1 line offset bits, 2 replacement policy); write only while the block is idle
// - an access is scanned one way per cycle through the single read port of the tag
//   memory and the shared compare unit; a hit ends the scan at the matching way, a
//   miss scans every way; the chosen way is updated as the result is registered
// - req.ready is high only while idle, one access at a time; the next access can be
//   taken the cycle after the result is registered
// - results sit in an output register; if rsp is stalled the block still takes the
//   next access and holds its finished result until the register frees up
// - reset clears all valid and dirty bits, the access counter and output valid flag,
//   loads the random generator seed and the configuration defaults; no clearing pass
module set_assoc_cache_tag_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sact_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [sact_pkg::CFG_W-1:0]    cfg_data,
	sact_req_if.sink                      req,
	sact_rsp_if.source                    rsp
);

	sact_pkg::state_t                   state_q, state_d;

	logic [sact_pkg::SIB_W-1:0]         sib_q;
	logic [sact_pkg::LOB_W-1:0]         lob_q;
	logic [sact_pkg::POL_W-1:0]         pol_q;

	logic [sact_pkg::STAMP_W-1:0]       counter_q;
	logic [sact_pkg::LFSR_W-1:0]        lfsr_q;
	logic [sact_pkg::LFSR_W-1:0]        lfsr_nx;

	logic [sact_pkg::MAX_SETS-1:0][sact_pkg::NUM_WAYS-1:0] valid_q;
	logic [sact_pkg::MAX_SETS-1:0][sact_pkg::NUM_WAYS-1:0] dirty_q;

	logic [sact_pkg::ADDR_W-1:0]        line_q;
	logic [sact_pkg::SET_W-1:0]         set_q;
	logic                               wr_q;
	logic [sact_pkg::WAY_W-1:0]         way_q;
	logic                               hit_q;
	logic [sact_pkg::WAY_W-1:0]         hit_way_q;
	logic [sact_pkg::STAMP_W-1:0]       min_q;
	logic [sact_pkg::WAY_W-1:0]         min_way_q;

	sact_pkg::rsp_t                     out_q;
	logic                               out_valid_q;

	logic [sact_pkg::ADDR_W-1:0]        line_d;
	logic [sact_pkg::ADDR_W-1:0]        set_mask;
	logic [sact_pkg::SET_W-1:0]         set_d;
	logic                               accept;
	logic                               fire;
	logic                               last_way;
	logic [sact_pkg::ENTRY_W-1:0]       raddr;

	logic [sact_pkg::NUM_WAYS-1:0]      row_valid;
	logic                               any_inv;
	logic [sact_pkg::WAY_W-1:0]         inv_way;
	logic                               rand_pol;
	logic                               use_lfsr;
	logic [sact_pkg::WAY_W-1:0]         tgt_way;
	logic                               tgt_wb;
	logic                               ram_we;

	sact_pkg::entry_t                   rd_entry;
	sact_pkg::entry_t                   wr_entry;
	sact_pkg::cmp_t                     cmp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sib_q <= sact_pkg::SIB_RESET;
			lob_q <= sact_pkg::LOB_RESET;
			pol_q <= sact_pkg::POL_LRU;
		end else if (cfg_we) begin
			case (cfg_idx)
				sact_pkg::REG_SET_INDEX_BITS:     sib_q <= cfg_data[sact_pkg::SIB_W-1:0];
				sact_pkg::REG_LINE_OFFSET_BITS:   lob_q <= cfg_data[sact_pkg::LOB_W-1:0];
				sact_pkg::REG_REPLACEMENT_POLICY: pol_q <= cfg_data[sact_pkg::POL_W-1:0];
				default: ;
			endcase
		end
	end

	// line address and set index of the incoming access
	always_comb begin
		line_d   = req.payload.address >> lob_q;
		set_mask = (32'd1 << sib_q) - 32'd1;
		set_d    = sact_pkg::SET_W'(line_d & set_mask);
	end

	assign last_way = (way_q == sact_pkg::WAY_W'(sact_pkg::NUM_WAYS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sact_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		fire      = 1'b0;
		raddr     = sact_pkg::entry_addr(set_q, sact_pkg::WAY_W'(way_q + 1'b1));
		case (state_q)
			sact_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				raddr     = sact_pkg::entry_addr(set_d, '0);
				if (req.valid) begin
					state_d = sact_pkg::ST_SCAN;
				end
			end
			sact_pkg::ST_SCAN: begin
				if (cmp.match || last_way) begin
					state_d = sact_pkg::ST_FINISH;
				end
			end
			sact_pkg::ST_FINISH: begin
				fire = !out_valid_q || rsp.ready;
				if (fire) begin
					state_d = sact_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sact_pkg::ST_IDLE;
			end
		endcase
	end

	sact_tag_ram u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sact_pkg::entry_addr(set_q, tgt_way)),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	assign row_valid = valid_q[set_q];

	sact_cmp_unit u_cmp (
		.entry       (rd_entry),
		.entry_valid (row_valid[way_q]),
		.line        (line_q),
		.min_stamp   (min_q),
		.res         (cmp)
	);

	// scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			hit_q     <= 1'b0;
			way_q     <= '0;
		end else begin
			if (accept) begin
				counter_q <= counter_q + 1'b1;
				hit_q     <= 1'b0;
				way_q     <= '0;
			end else if (state_q == sact_pkg::ST_SCAN) begin
				if (cmp.match) begin
					hit_q <= 1'b1;
				end else if (!last_way) begin
					way_q <= sact_pkg::WAY_W'(way_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= line_d;
			set_q  <= set_d;
			wr_q   <= req.payload.is_store;
		end
		if (state_q == sact_pkg::ST_SCAN) begin
			if (cmp.match) begin
				hit_way_q <= way_q;
			end
			if (way_q == '0 || cmp.less) begin
				min_q     <= rd_entry.stamp;
				min_way_q <= way_q;
			end
		end
	end

	// way selection for the update
	always_comb begin
		any_inv = 1'b0;
		inv_way = '0;
		for (int w = sact_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (!row_valid[w]) begin
				any_inv = 1'b1;
				inv_way = sact_pkg::WAY_W'(w);
			end
		end
	end

	assign rand_pol = pol_q inside {sact_pkg::POL_RANDOM, sact_pkg::POL_RANDOM_ALT};
	assign lfsr_nx  = sact_pkg::lfsr_next(lfsr_q);
	assign use_lfsr = !hit_q && !any_inv && rand_pol;

	always_comb begin
		tgt_wb = 1'b0;
		if (hit_q) begin
			tgt_way = hit_way_q;
		end else if (any_inv) begin
			tgt_way = inv_way;
		end else begin
			if (rand_pol) begin
				tgt_way = sact_pkg::WAY_W'(lfsr_nx % sact_pkg::LFSR_W'(sact_pkg::NUM_WAYS));
			end else begin
				tgt_way = min_way_q;
			end
			tgt_wb = dirty_q[set_q][tgt_way];
		end
	end

	assign ram_we         = fire && (!hit_q || pol_q == sact_pkg::POL_LRU);
	assign wr_entry.tag   = line_q;
	assign wr_entry.stamp = counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= sact_pkg::LFSR_SEED;
		end else if (fire && use_lfsr) begin
			lfsr_q <= lfsr_nx;
		end
	end

	// valid and dirty bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
		end else if (fire) begin
			if (hit_q) begin
				if (wr_q) begin
					dirty_q[set_q][tgt_way] <= 1'b1;
				end
			end else begin
				valid_q[set_q][tgt_way] <= 1'b1;
				dirty_q[set_q][tgt_way] <= wr_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.hit             <= hit_q;
			out_q.needs_writeback <= tgt_wb;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// checks
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == sact_pkg::ST_FINISH))
		else $error("result appeared without a finished access");

	a_accept_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == sact_pkg::ST_SCAN))
		else $error("accepted access did not start a scan");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.hit && rsp.payload.needs_writeback))
		else $error("hit reported with a writeback");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (counter_q == $past(counter_q) + 1'b1))
		else $error("access counter did not advance by one");

endmodule

@@ sim/sact_access_checker.sv @@
`timescale 1ns / 100ps
// sact_access_checker: tracks the tag, dirty and stamp state of every line, predicts
// hit and writeback for each access transfer and compares each result transfer in order
// depends on sact_pkg, sact_req_if and sact_rsp_if
module sact_access_checker
	import sact_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	sact_req_if               req,
	sact_rsp_if               rsp,
	output int                mismatches,
	output int                outstanding
);

	logic               line_valid [ENTRIES];
	logic               line_dirty [ENTRIES];
	logic [ADDR_W-1:0]  line_tag   [ENTRIES];
	logic [STAMP_W-1:0] line_stamp [ENTRIES];
	logic [STAMP_W-1:0] access_count;
	logic [LFSR_W-1:0]  victim_lfsr;
	logic [SIB_W-1:0]   sib;
	logic [LOB_W-1:0]   lob;
	logic [POL_W-1:0]   policy;
	rsp_t               outcome_q [$];
	rsp_t               want;
	int                 result_no;

	task automatic report_mismatch(input string msg);
		$display("%0t: result %0d: %s", $time, result_no, msg);
		mismatches = mismatches + 1;
	endtask

	task automatic lookup_access(input logic [ADDR_W-1:0] address, input logic is_store,
			output rsp_t outcome);
		logic [ADDR_W-1:0] line;
		logic [SET_W-1:0]  set_idx;
		int                base;
		int                slot;
		int                victim;
		access_count = access_count + 1'b1;
		line = address >> lob;
		// sets past storage alias lower ones
		set_idx = SET_W'(line & ((32'd1 << sib) - 32'd1));
		base = int'(set_idx) * NUM_WAYS;
		outcome = '0;
		slot = -1;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (slot < 0 && line_valid[base + w] && line_tag[base + w] == line) begin
				slot = base + w;
			end
		end
		if (slot >= 0) begin
			if (policy == POL_LRU) begin
				line_stamp[slot] = access_count;
			end
			if (is_store) begin
				line_dirty[slot] = 1'b1;
			end
			outcome.hit = 1'b1;
			return;
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (slot < 0 && !line_valid[base + w]) begin
				slot = base + w;
			end
		end
		if (slot < 0) begin
			// bit 1 of the policy selects random choice
			if (policy[1]) begin
				victim_lfsr = {1'b0, victim_lfsr[LFSR_W-1:1]} ^
					(victim_lfsr[0] ? LFSR_TAPS : '0);
				victim = int'(victim_lfsr) % NUM_WAYS;
			end else begin
				// lowest way wins on equal stamps
				victim = 0;
				for (int w = 1; w < NUM_WAYS; w++) begin
					if (line_stamp[base + w] < line_stamp[base + victim]) begin
						victim = w;
					end
				end
			end
			slot = base + victim;
			outcome.needs_writeback = line_dirty[slot];
		end
		line_valid[slot] = 1'b1;
		line_tag[slot]   = line;
		line_dirty[slot] = is_store;
		line_stamp[slot] = access_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++) begin
				line_valid[e] = 1'b0;
				line_dirty[e] = 1'b0;
			end
			access_count = '0;
			victim_lfsr  = LFSR_SEED;
			sib          = SIB_RESET;
			lob          = LOB_RESET;
			policy       = POL_LRU;
			outcome_q.delete();
			result_no    = 0;
			mismatches   = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SET_INDEX_BITS: begin
						sib = cfg_data[SIB_W-1:0];
					end
					REG_LINE_OFFSET_BITS: begin
						lob = cfg_data[LOB_W-1:0];
					end
					REG_REPLACEMENT_POLICY: begin
						policy = cfg_data[POL_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result transfer with no access outstanding");
				end else begin
					want = outcome_q.pop_front();
					if (rsp.payload.hit !== want.hit) begin
						report_mismatch($sformatf("hit %b, expected %b",
							rsp.payload.hit, want.hit));
					end
					if (rsp.payload.needs_writeback !== want.needs_writeback) begin
						report_mismatch($sformatf("needs_writeback %b, expected %b",
							rsp.payload.needs_writeback, want.needs_writeback));
					end
				end
				result_no = result_no + 1;
			end
			if (req.valid && req.ready) begin
				lookup_access(req.payload.address, req.payload.is_store, want);
				outcome_q.push_back(want);
			end
			outstanding <= outcome_q.size();
		end
	end

endmodule

@@ sim/set_assoc_cache_tag_controller_test.sv @@
`timescale 1ns / 100ps
// set_assoc_cache_tag_controller_test: drives accesses and configuration phases into the
// tag controller, with random gaps and stalls; depends on sact_pkg, the channel
// interfaces, the block and sact_access_checker
module set_assoc_cache_tag_controller_test;
	import sact_pkg::*;

	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 217;
	localparam int QUIET_LIMIT     = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;
	int                mismatches;
	int                outstanding;
	int                send_idle_pct;
	int                rsp_stall_pct;
	int                quiet_cycles = 0;
	logic [ADDR_W-1:0] region;
	logic [LOB_W-1:0]  cur_lob;

	logic [SIB_W-1:0] phase_sib [NUM_PHASES] = '{3'd6, 3'd0, 3'd7, 3'd2, 3'd6, 3'd1, 3'd7,
		3'd3, 3'd0};
	logic [LOB_W-1:0] phase_lob [NUM_PHASES] = '{4'd4, 4'd0, 4'd15, 4'd8, 4'd4, 4'd15, 4'd0,
		4'd2, 4'd8};
	logic [POL_W-1:0] phase_pol [NUM_PHASES] = '{POL_LRU, POL_FIFO, POL_RANDOM,
		POL_RANDOM_ALT, POL_FIFO, POL_LRU, POL_LRU, POL_RANDOM, POL_RANDOM_ALT};

	// set 0 filled, hit refresh, clean and dirty evictions, address extremes
	req_t directed_accesses [14] = '{
		'{32'h0000_0000, 1'b0}, '{32'h0000_0000, 1'b1}, '{32'hFFFF_FFFF, 1'b1},
		'{32'hFFFF_FFF0, 1'b0}, '{32'h0000_0400, 1'b0}, '{32'h0000_0800, 1'b1},
		'{32'h0000_0C00, 1'b0}, '{32'h0000_0004, 1'b0}, '{32'h0000_1000, 1'b0},
		'{32'h0000_0400, 1'b1}, '{32'h0000_0C00, 1'b1}, '{32'h8000_0000, 1'b0},
		'{32'h7FFF_FFFF, 1'b1}, '{32'h0000_0C08, 1'b0}
	};

	sact_req_if req();
	sact_rsp_if rsp();

	set_assoc_cache_tag_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	sact_access_checker access_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("set_assoc_cache_tag_controller: mismatch");
			$finish;
		end
	end

	task automatic send_access(input logic [ADDR_W-1:0] address, input logic is_store);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.payload <= {address, is_store};
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
	endtask

	// hold off until every outstanding result has been transferred
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic configure(input logic [SIB_W-1:0] sib, input logic [LOB_W-1:0] lob,
			input logic [POL_W-1:0] pol);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SET_INDEX_BITS;
		cfg_data <= CFG_W'(sib);
		@(posedge clk);
		cfg_idx  <= REG_LINE_OFFSET_BITS;
		cfg_data <= CFG_W'(lob);
		@(posedge clk);
		cfg_idx  <= REG_REPLACEMENT_POLICY;
		cfg_data <= CFG_W'(pol);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_lob = lob;
		region  = $urandom();
	endtask

	// mostly a small pool of lines crowding a few sets, the rest anywhere
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] line;
		if ($urandom_range(0, 99) < 15) begin
			return $urandom();
		end
		line = region + (ADDR_W'($urandom_range(0, 5)) << 7) + ADDR_W'($urandom_range(0, 3))
			+ ($urandom_range(0, 1) ? 32'd64 : 32'd0);
		return (line << cur_lob) | ($urandom() & ((32'd1 << cur_lob) - 32'd1));
	endfunction

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_idx     <= REG_SET_INDEX_BITS;
		cfg_data    <= '0;
		req.valid   <= 1'b0;
		req.payload <= '0;
		send_idle_pct = 17;
		rsp_stall_pct = 74;
		cur_lob = LOB_RESET;
		region  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_accesses[i]) begin
			send_access(directed_accesses[i].address, directed_accesses[i].is_store);
		end
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 3) begin
				send_idle_pct = 74;
				rsp_stall_pct = 17;
			end else if (p == 6) begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			configure(phase_sib[p], phase_lob[p], phase_pol[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 199) == 0) begin
					drain();
				end
				send_access(pick_address(), 1'($urandom_range(0, 1)));
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("set_assoc_cache_tag_controller: match");
		end else begin
			$display("set_assoc_cache_tag_controller: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sact_pkg.sv
rtl/core/sact_req_if.sv
rtl/core/sact_rsp_if.sv
rtl/core/sact_tag_ram.sv
rtl/core/sact_cmp_unit.sv
rtl/core/set_assoc_cache_tag_controller.sv
sim/sact_access_checker.sv
sim/set_assoc_cache_tag_controller_test.sv
